FILE: sv/lph_pkg.sv
// Shared types, widths and codes of the linear probing hash table.
package lph_pkg;

    localparam int KEY_W           = 60;
    localparam int REC_W           = 32;
    localparam int HASH_W          = 10;
    localparam int IDX_W           = 6;
    localparam int TABLE_SLOTS_DEF = 47;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_SEARCH = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_FOUND   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef struct packed {
        t_action             action;
        logic [KEY_W-1:0]    student_key;
        logic [HASH_W-1:0]   hash_digits;
        logic [REC_W-1:0]    record_word;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [IDX_W-1:0]    slot_index;
        logic [REC_W-1:0]    found_record;
    } t_out_item;

    typedef struct packed {
        logic                used;
        logic [KEY_W-1:0]    key;
        logic [REC_W-1:0]    record;
    } t_entry;

endpackage

FILE: sv/linear_probe_hash_table.sv
// Top level: probe sequencer of the linear probing hash table.
//
//   channel   direction  handshake                   item
//   input     in         i_in_valid / o_in_ready     i_in_item  (t_in_item)
//   output    out        o_out_valid / i_out_ready   o_out_item (t_out_item)
//
// After accept an item passes S_HASH, which finishes the home slot, then S_CHECK, which
// reads one slot from the slot memory per probe over P slots (1 to TABLE_SLOTS), then
// S_OUT, which loads the output register, and S_IDLE before the next accept.
// After reset a clearing pass marks every slot free; no item is accepted during it. A
// stalled output holds its item while the next one is taken and worked on; that item
// waits in the result register until the output frees up.
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lph_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lph_pkg::t_out_item  o_out_item
);
    import lph_pkg::*;

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_OUT
    } t_state;

    t_state             r_state,  n_state;
    logic [SLOT_W-1:0]  r_pos,    n_pos;
    logic [SLOT_W-1:0]  r_cnt,    n_cnt;
    t_in_item           r_item,   n_item;
    t_out_item          r_res,    n_res;
    t_out_item          r_out,    n_out;
    logic               r_out_valid, n_out_valid;

    logic               accept;
    logic               home_done;
    logic [SLOT_W-1:0]  home;
    logic [SLOT_W-1:0]  pos_next;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    t_entry             wr_data;
    logic [SLOT_W-1:0]  rd_addr;
    t_entry             rd_data;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pos_next    = (r_pos == LAST_SLOT) ? '0 : r_pos + 1'b1;

    lph_home #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_home (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_digits (i_in_item.hash_digits),
        .o_done   (home_done),
        .o_home   (home)
    );

    lph_store #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequence the clearing pass, the probe walk and the result hand-off
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = '{used: 1'b0, key: r_item.student_key, record: r_item.record_word};
        rd_addr     = r_pos;

        // drop the output item once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (r_pos == LAST_SLOT) begin
                    n_pos   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_pos = pos_next;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_item  = i_in_item;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                // read the home slot as soon as it is known
                if (home_done) begin
                    rd_addr = home;
                    n_pos   = home;
                    n_cnt   = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // fetch the following slot in case this one does not settle it
                rd_addr = pos_next;
                n_pos   = pos_next;
                n_cnt   = r_cnt + 1'b1;
                if (r_item.action == ACT_INSERT) begin
                    if (!rd_data.used) begin
                        wr_en        = 1'b1;
                        wr_data.used = 1'b1;
                        n_res   = '{status: ST_STORED, slot_index: IDX_W'(r_pos),
                                    found_record: '0};
                        n_state = S_OUT;
                    end else if (r_cnt == LAST_SLOT) begin
                        n_res   = '{status: ST_FULL, slot_index: '0, found_record: '0};
                        n_state = S_OUT;
                    end
                end else begin
                    if (!rd_data.used || (rd_data.key != r_item.student_key)) begin
                        if (!rd_data.used || (r_cnt == LAST_SLOT)) begin
                            n_res   = '{status: ST_MISSING, slot_index: '0,
                                        found_record: '0};
                            n_state = S_OUT;
                        end
                    end else begin
                        n_res   = '{status: ST_FOUND, slot_index: IDX_W'(r_pos),
                                    found_record: rd_data.record};
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_pos   = '0;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_item      <= n_item;
            r_res       <= n_res;
            r_out       <= n_out;
        end
    end

endmodule

FILE: sv/lph_home.sv
// Home slot of the hash digits: reciprocal multiply at the start, remainder the next cycle.
module lph_home #(
    parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEF,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lph_pkg::HASH_W-1:0] i_digits,
    output logic                      o_done,
    output logic [SLOT_W-1:0]         o_home
);
    import lph_pkg::*;

    // Quotient by reciprocal: exact for every digit value since 2^SLOT_W >= TABLE_SLOTS
    localparam int SHIFT   = HASH_W + SLOT_W;
    localparam int RECIP_W = HASH_W + 2;
    localparam int PROD_W  = HASH_W + RECIP_W;
    localparam int BACK_W  = HASH_W + SLOT_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << SHIFT) + TABLE_SLOTS - 1) / TABLE_SLOTS);
    localparam logic [BACK_W-1:0]  SLOTS_C = BACK_W'(TABLE_SLOTS);

    logic                r_busy;
    logic [HASH_W-1:0]   r_val;
    logic [HASH_W-1:0]   r_quot;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   quot_wide;
    logic [BACK_W-1:0]   back;
    logic [BACK_W-1:0]   rem;

    // Estimate the quotient from the incoming digits
    assign prod      = PROD_W'(i_digits) * PROD_W'(RECIP);
    assign quot_wide = prod >> SHIFT;

    // Subtract the multiple of the slot count from the held digits
    assign back   = BACK_W'(r_quot) * SLOTS_C;
    assign rem    = BACK_W'(r_val) - back;
    assign o_done = r_busy;
    assign o_home = rem[SLOT_W-1:0];

    // Capture the digits and the quotient on start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
            if (i_start) begin
                r_val  <= i_digits;
                r_quot <= quot_wide[HASH_W-1:0];
            end
        end
    end

endmodule

FILE: sv/lph_store.sv
// Slot memory: one write port, one read port with registered read data.
module lph_store #(
    parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEF,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [SLOT_W-1:0]     i_wr_addr,
    input  lph_pkg::t_entry       i_wr_data,
    input  logic [SLOT_W-1:0]     i_rd_addr,
    output lph_pkg::t_entry       o_rd_data
);
    import lph_pkg::*;

    t_entry r_mem [TABLE_SLOTS];
    t_entry r_rd_data;

    // Write when enabled, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the linear probing hash table: table walk, random fill, stalls.
module tb;
    import lph_pkg::*;

    localparam int SLOTS       = TABLE_SLOTS_DEF;
    localparam int RANDOM_RUN  = 1533;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 400;
    localparam int DRAIN_AT    = 900;
    localparam int TAIL_CYCLES = 80;
    localparam int LIMIT       = 800000;

    typedef enum int {RX_OPEN, RX_MASK, RX_COIN, RX_SKIP} t_rx_mode;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item answer;
    } t_row;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] digits;
    } t_known;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // Mirror of the table contents
    bit                slot_taken [SLOTS];
    logic [KEY_W-1:0]  slot_keys  [SLOTS];
    logic [REC_W-1:0]  slot_recs  [SLOTS];

    t_out_item pending_answers[$];
    t_row      table_walk[$];
    t_known    known_keys[$];

    int        errors = 0;
    int        cycles = 0;
    int        items_sent = 0;
    int        burst_left = 0;
    int        status_tally[4];
    bit        hold_req = 1'b0;
    t_out_item want;

    linear_probe_hash_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_answers.size());
            $display("FAIL linear_probe_hash_table");
            $finish;
        end
    end

    // Walk the probe sequence on the mirror and update it like the block does
    function automatic t_out_item probe_table(input t_in_item it);
        t_out_item r;
        int        pos;
        bit        done;
        pos  = int'(it.hash_digits) % SLOTS;
        done = 1'b0;
        r    = '0;
        if (it.action == ACT_INSERT) begin
            r.status = ST_FULL;
            for (int n = 0; n < SLOTS; n++) begin
                if (!done && !slot_taken[pos]) begin
                    slot_taken[pos] = 1'b1;
                    slot_keys[pos]  = it.student_key;
                    slot_recs[pos]  = it.record_word;
                    r.status        = ST_STORED;
                    r.slot_index    = IDX_W'(pos);
                    done            = 1'b1;
                end
                if (!done)
                    pos = (pos + 1 == SLOTS) ? 0 : pos + 1;
            end
        end else begin
            r.status = ST_MISSING;
            for (int n = 0; n < SLOTS; n++) begin
                if (!done) begin
                    if (!slot_taken[pos]) begin
                        done = 1'b1;
                    end else if (slot_keys[pos] == it.student_key) begin
                        r.status       = ST_FOUND;
                        r.slot_index   = IDX_W'(pos);
                        r.found_record = slot_recs[pos];
                        done           = 1'b1;
                    end else begin
                        pos = (pos + 1 == SLOTS) ? 0 : pos + 1;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic add_row(input t_action act, input logic [KEY_W-1:0] key,
                           input logic [HASH_W-1:0] digits, input logic [REC_W-1:0] rec,
                           input bit typed, input t_status st, input int idx,
                           input logic [REC_W-1:0] rec_out);
        t_row row;
        row.item.action       = act;
        row.item.student_key  = key;
        row.item.hash_digits  = digits;
        row.item.record_word  = rec;
        row.typed             = typed;
        row.answer.status     = st;
        row.answer.slot_index = IDX_W'(idx);
        row.answer.found_record = rec_out;
        table_walk.push_back(row);
    endtask

    // Present an item, hold it until taken, then log what should come back
    task automatic offer(input t_in_item it, input bit typed, input t_out_item typed_ans);
        t_out_item ans;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        ans = probe_table(it);
        pending_answers.push_back(typed ? typed_ans : ans);
        if (it.action == ACT_INSERT)
            known_keys.push_back({it.student_key, it.hash_digits});
        items_sent++;
    endtask

    // Idle the sender between bursts
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 6);
            burst_left = $urandom_range(0, 15);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Receiver: switch between random stall patterns, one long hold-off on request
    initial begin : receiver
        t_rx_mode   mode;
        int         phase;
        int         hold_cnt;
        logic [7:0] mask;
        bit         hold_taken;
        mode       = RX_OPEN;
        phase      = 0;
        mask       = 8'hff;
        hold_taken = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_out_ready <= 1'b0;
                for (hold_cnt = 1; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge i_clk);
            end else begin
                if (phase % 256 == 0) begin
                    mode = t_rx_mode'($urandom_range(3));
                    mask = 8'($urandom_range(1, 255));
                end
                case (mode)
                    RX_OPEN: i_out_ready <= 1'b1;
                    RX_MASK: i_out_ready <= mask[phase % 8];
                    RX_COIN: i_out_ready <= 1'($urandom_range(1));
                    default: i_out_ready <= (phase % 8 != 0);
                endcase
                phase++;
            end
        end
    end

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d slot %0d record %h",
                         $time, o_out_item.status, o_out_item.slot_index,
                         o_out_item.found_record);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (o_out_item.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_out_item.status);
                    errors++;
                end
                if (o_out_item.slot_index !== want.slot_index) begin
                    $display("%0t: slot_index expected %0d actual %0d", $time,
                             want.slot_index, o_out_item.slot_index);
                    errors++;
                end
                if (o_out_item.found_record !== want.found_record) begin
                    $display("%0t: found_record expected %h actual %h", $time,
                             want.found_record, o_out_item.found_record);
                    errors++;
                end
                status_tally[want.status]++;
            end
        end
    end

    // Stimulus: directed table walk, then random fill of the table
    initial begin : stimulus
        t_in_item it;
        t_known   pick;
        int       roll;
        int       used_slots;
        for (int s = 0; s < SLOTS; s++)
            slot_taken[s] = 1'b0;

        // Empty table, extremes of key, digits and record
        add_row(ACT_SEARCH, '0, 10'd0, '0, 1, ST_MISSING, 0, '0);
        add_row(ACT_INSERT, '0, 10'd0, '0, 1, ST_STORED, 0, '0);
        add_row(ACT_INSERT, {KEY_W{1'b1}}, 10'd1023, 32'hffff_ffff, 1, ST_STORED, 36, '0);
        add_row(ACT_SEARCH, {KEY_W{1'b1}}, 10'd1023, '0, 1, ST_FOUND, 36, 32'hffff_ffff);
        // Duplicate key collides at its home slot
        add_row(ACT_INSERT, 60'd5, 10'd999, 32'd1, 1, ST_STORED, 12, '0);
        add_row(ACT_INSERT, 60'd5, 10'd999, 32'd2, 1, ST_STORED, 13, '0);
        add_row(ACT_SEARCH, 60'd5, 10'd12, 32'hdead_beef, 1, ST_FOUND, 12, 32'd1);
        add_row(ACT_SEARCH, 60'd5, 10'd13, '0, 1, ST_FOUND, 13, 32'd2);
        // Wrap around the last slot
        add_row(ACT_INSERT, 60'd7, 10'd46, 32'd3, 1, ST_STORED, 46, '0);
        add_row(ACT_INSERT, 60'd8, 10'd93, 32'd4, 1, ST_STORED, 1, '0);
        add_row(ACT_SEARCH, 60'd8, 10'd46, '0, 1, ST_FOUND, 1, 32'd4);
        add_row(ACT_SEARCH, 60'd9, 10'd46, '0, 1, ST_MISSING, 0, '0);
        add_row(ACT_SEARCH, '0, 10'd47, '0, 1, ST_FOUND, 0, '0);
        // Alternating bit patterns, probe past other keys
        add_row(ACT_INSERT, {15{4'h5}}, 10'h2aa, 32'haaaa_aaaa, 1, ST_STORED, 24, '0);
        add_row(ACT_INSERT, {15{4'ha}}, 10'h155, 32'h5555_5555, 0, ST_STORED, 0, '0);
        add_row(ACT_SEARCH, {15{4'ha}}, 10'd12, '0, 0, ST_STORED, 0, '0);
        add_row(ACT_SEARCH, {15{4'h5}}, 10'd24, '0, 1, ST_FOUND, 24, 32'haaaa_aaaa);
        // Digits above 999 still reduce
        add_row(ACT_INSERT, 60'd11, 10'd1000, 32'd6, 0, ST_STORED, 0, '0);
        add_row(ACT_SEARCH, 60'd12, 10'd36, '0, 1, ST_MISSING, 0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (table_walk[r]) begin
            offer(table_walk[r].item, table_walk[r].typed, table_walk[r].answer);
            pace();
        end

        // Random part: sparse inserts fill the table slowly, searches mostly hit known keys
        for (int k = 0; k < RANDOM_RUN; k++) begin
            it   = '0;
            roll = $urandom_range(99);
            it.record_word = $urandom();
            if (roll < 5) begin
                it.action = ACT_INSERT;
                if (known_keys.size() != 0 && $urandom_range(3) == 0) begin
                    pick = known_keys[$urandom_range(known_keys.size() - 1)];
                    it.student_key = pick.key;
                    it.hash_digits = pick.digits;
                end else begin
                    it.student_key = KEY_W'({$urandom(), $urandom()});
                    it.hash_digits = HASH_W'($urandom_range(1023));
                end
            end else begin
                it.action = ACT_SEARCH;
                if (known_keys.size() != 0 && roll < 85) begin
                    pick = known_keys[$urandom_range(known_keys.size() - 1)];
                    it.student_key = pick.key;
                    if (roll >= 70)
                        it.student_key[$urandom_range(KEY_W - 1)] ^= 1'b1;
                    if ($urandom_range(1) == 0)
                        it.hash_digits = pick.digits;
                    else
                        it.hash_digits = HASH_W'(int'(pick.digits) % SLOTS
                                                 + SLOTS * $urandom_range(20));
                end else begin
                    it.student_key = KEY_W'({$urandom(), $urandom()});
                    it.hash_digits = HASH_W'($urandom_range(1023));
                end
            end
            if (k == HOLD_AT)
                hold_req = 1'b1;
            offer(it, 1'b0, '0);
            if (k == DRAIN_AT) begin
                i_in_valid <= 1'b0;
                while (pending_answers.size() != 0) @(posedge i_clk);
            end else if (k != RANDOM_RUN - 1) begin
                pace();
            end
        end

        // Drain and let any stray result show up
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        used_slots = 0;
        for (int s = 0; s < SLOTS; s++)
            used_slots += slot_taken[s];
        $display("Ran %0d items: %0d stored, %0d refused on a full table, %0d found, %0d missed",
                 items_sent, status_tally[ST_STORED], status_tally[ST_FULL],
                 status_tally[ST_FOUND], status_tally[ST_MISSING]);
        $display("Table ended with %0d of %0d slots used, %0d mismatches", used_slots, SLOTS,
                 errors);
        if (errors == 0) begin
            $display("PASS linear_probe_hash_table");
        end else begin
            $display("FAIL linear_probe_hash_table");
        end
        $finish;
    end

endmodule
